FILE: hw/rtl/spv_pkg.sv
// shared types and constants for the sampler voice
package spv_pkg;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int FRAC_BITS = 16;
  localparam int AW = 16;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [2:0] REG_ATTACK = 3'd0;
  localparam logic [2:0] REG_DECAY = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_SUSTAIN = 3'd3;
  localparam logic [2:0] REG_LENGTH = 3'd4;
  localparam logic [2:0] REG_STEREO = 3'd5;

  localparam logic [24:0] ENV_ONE = 25'd16777216;
  localparam logic [24:0] ATTACK_TARGET = 25'd20132659;
  localparam logic [24:0] DECAY_NEAR = 25'd16777;
  localparam logic [24:0] RELEASE_FLOOR = 25'd168;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ATTACK = 3'd1,
    PH_DECAY = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // datapath step commands from the controller
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ENV_MUL = 3'd1,
    OP_ENV_FIN = 3'd2,
    OP_RD0 = 3'd3,
    OP_RD1 = 3'd4,
    OP_INTERP = 3'd5,
    OP_SCALE1 = 3'd6,
    OP_SCALE2 = 3'd7
  } op_t;

  typedef struct packed {
    op_t op;
    logic start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic skip;
  } sts_t;

endpackage

FILE: hw/rtl/sample_player_voice_adsr.sv
// top level of the sampler voice with adsr envelope
// One word is taken at a time. A load, note-on or note-off word holds the
// input through decode only; a tick word holds it through decode, two envelope
// steps, two sample memory reads through the single read port,
// interpolation, two scaling multiplies and finish, with its result word
// registered as it leaves the finish state. An idle or empty-sample tick
// goes from decode straight to finish and registers its result there. The
// result sits in an output register, so the next word may be accepted while
// it waits; the sequencer only holds in its finish state while the previous
// result is still unclaimed. The sample memory holds 65536 frames and the
// play position carries 16 fraction bits. Sample memory is not cleared:
// reading an unloaded frame inside the sample length is undefined.
module sample_player_voice_adsr (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [15:0]        sample_address,
  input  logic signed [15:0] sample_left,
  input  logic signed [15:0] sample_right,
  input  logic [15:0]        velocity,
  input  logic [23:0]        pitch_step,
  input  logic               tail_off,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic [24:0]        env_value,
  output logic               voice_active,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import spv_pkg::*;

  logic [23:0] attack_coeff, decay_coeff, release_coeff;
  logic [24:0] sustain_level;
  logic [16:0] sample_length;
  logic source_stereo;

  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic [2:0] ridx;
  logic wr;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr = psel && penable && pwrite && pready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff <= '0;
      decay_coeff <= '0;
      release_coeff <= '0;
      sustain_level <= ENV_ONE;
      sample_length <= '0;
      source_stereo <= 1'b0;
    end else if (wr) begin
      unique case (ridx)
        REG_ATTACK: attack_coeff <= pwdata[23:0];
        REG_DECAY: decay_coeff <= pwdata[23:0];
        REG_RELEASE: release_coeff <= pwdata[23:0];
        REG_SUSTAIN: sustain_level <= pwdata[24:0];
        REG_LENGTH: sample_length <= pwdata[16:0];
        REG_STEREO: source_stereo <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ATTACK: prdata = 32'(attack_coeff);
      REG_DECAY: prdata = 32'(decay_coeff);
      REG_RELEASE: prdata = 32'(release_coeff);
      REG_SUSTAIN: prdata = 32'(sustain_level);
      REG_LENGTH: prdata = 32'(sample_length);
      REG_STEREO: prdata = 32'(source_stereo);
      default: prdata = '0;
    endcase
  end

  // input side: one word in flight at a time
  assign in_stall = busy;

  // output register: loaded at writeback, cleared when taken
  logic res_due;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_due) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  // every tick, skip ticks included, finishes through the FIN state
  assign res_due = cmd.finish;

  spv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_valid && !in_stall), .sts(sts),
    .out_busy(out_valid && out_stall), .cmd(cmd), .busy(busy)
  );

  spv_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kind(kind), .sample_address(sample_address), .sample_left(sample_left),
    .sample_right(sample_right), .velocity(velocity), .pitch_step(pitch_step),
    .tail_off(tail_off), .attack_coeff(attack_coeff), .decay_coeff(decay_coeff),
    .release_coeff(release_coeff), .sustain_level(sustain_level),
    .sample_length(sample_length), .source_stereo(source_stereo),
    .res_left(out_left), .res_right(out_right), .res_env(env_value),
    .res_active(voice_active)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("accept while busy");
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !res_due) else $error("result overwritten");
endmodule

FILE: hw/rtl/spv_ctrl.sv
// tick sequencer for the sampler voice
module spv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_go,
  input  spv_pkg::sts_t sts,
  input  logic          out_busy,
  output spv_pkg::cmd_t cmd,
  output logic          busy
);
  import spv_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DEC = 10'b0000000010,
    S_EM = 10'b0000000100,
    S_EF = 10'b0000001000,
    S_R0 = 10'b0000010000,
    S_R1 = 10'b0000100000,
    S_IP = 10'b0001000000,
    S_S1 = 10'b0010000000,
    S_S2 = 10'b0100000000,
    S_FIN = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '{op: OP_NONE, start: 1'b0, finish: 1'b0};
    unique case (state)
      S_IDLE: begin
        cmd.start = in_go;
        if (in_go) state_next = S_DEC;
      end
      S_DEC: begin
        if (!sts.is_tick) state_next = S_IDLE;
        else if (sts.skip) state_next = S_FIN;
        else state_next = S_EM;
      end
      S_EM: begin cmd.op = OP_ENV_MUL; state_next = S_EF; end
      S_EF: begin cmd.op = OP_ENV_FIN; state_next = S_R0; end
      S_R0: begin cmd.op = OP_RD0; state_next = S_R1; end
      S_R1: begin cmd.op = OP_RD1; state_next = S_IP; end
      S_IP: begin cmd.op = OP_INTERP; state_next = S_S1; end
      S_S1: begin cmd.op = OP_SCALE1; state_next = S_S2; end
      S_S2: begin cmd.op = OP_SCALE2; state_next = S_FIN; end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == S_IDLE) else $error("start while busy");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_busy) else $error("finish over held word");
endmodule

FILE: hw/rtl/spv_dp.sv
// sampler voice datapath: envelope, sample memory, interpolation, scaling
module spv_dp (
  input  logic                clk,
  input  logic                rst,
  input  spv_pkg::cmd_t       cmd,
  output spv_pkg::sts_t       sts,
  input  logic [1:0]          kind,
  input  logic [15:0]         sample_address,
  input  logic signed [15:0]  sample_left,
  input  logic signed [15:0]  sample_right,
  input  logic [15:0]         velocity,
  input  logic [23:0]         pitch_step,
  input  logic                tail_off,
  input  logic [23:0]         attack_coeff,
  input  logic [23:0]         decay_coeff,
  input  logic [23:0]         release_coeff,
  input  logic [24:0]         sustain_level,
  input  logic [16:0]         sample_length,
  input  logic                source_stereo,
  output logic signed [15:0]  res_left,
  output logic signed [15:0]  res_right,
  output logic [24:0]         res_env,
  output logic                res_active
);
  import spv_pkg::*;

  // latched item
  logic [1:0] k_q;
  logic [15:0] a_q, vel_in_q;
  logic [31:0] w_q;
  logic [23:0] step_in_q;
  logic tail_q;
  logic dec_q;

  phase_t phase;
  logic [24:0] level;
  logic [32:0] pos;
  logic [15:0] vgain;
  logic [23:0] nstep;

  logic [31:0] mem [SAMPLE_DEPTH];
  logic [31:0] rd_q, w0_q;
  logic [16:0] len_eff;
  logic [24:0] sus;
  logic [24:0] env;
  logic [49:0] prod_a, prod_b;
  logic signed [15:0] il_q, ir_q;
  logic signed [41:0] ml_q, mr_q;

  // result of the tick in flight, moved to the output register at finish
  logic signed [15:0] hold_left, hold_right;
  logic [24:0] hold_env;
  logic hold_active;

  always_comb begin
    if (sample_length > 17'(SAMPLE_DEPTH)) len_eff = 17'(SAMPLE_DEPTH);
    else len_eff = sample_length;
    sus = (sustain_level > ENV_ONE) ? ENV_ONE : sustain_level;
  end

  logic phase_live;
  assign phase_live = (phase == PH_ATTACK) || (phase == PH_DECAY) ||
                      (phase == PH_SUSTAIN) || (phase == PH_RELEASE);
  assign sts.is_tick = (k_q == KIND_TICK);
  assign sts.skip = !phase_live || (len_eff == '0);

  // frame addresses
  logic [32-FRAC_BITS:0] i0;
  logic [32-FRAC_BITS+1:0] i1;
  logic [FRAC_BITS-1:0] frac;
  assign i0 = pos[32:FRAC_BITS];
  assign i1 = {1'b0, i0} + 18'd1;
  assign frac = pos[FRAC_BITS-1:0];
  logic in0, in1;
  assign in0 = ({1'b0, i0} < 18'(len_eff));
  assign in1 = (i1 < 18'(len_eff));

  // envelope multiply terms
  logic [23:0] coef;
  logic [24:0] tgt;
  always_comb begin
    case (phase)
      PH_ATTACK: begin coef = attack_coeff; tgt = ATTACK_TARGET; end
      PH_DECAY: begin coef = decay_coeff; tgt = sus; end
      default: begin coef = release_coeff; tgt = '0; end
    endcase
  end

  logic [50:0] env_sum;
  logic [24:0] lvl_new;
  assign env_sum = {1'b0, prod_a} + {1'b0, prod_b};
  assign lvl_new = env_sum[48:24];

  logic [32:0] pos_sum;
  logic [33:0] pos_add;
  assign pos_add = {1'b0, pos} + 34'(nstep);
  assign pos_sum = pos_add[33] ? '1 : pos_add[32:0];
  logic [33:0] len_pos;
  assign len_pos = 34'(len_eff) << FRAC_BITS;

  // next frame reads as zero past the end
  logic [31:0] rd1_mask;
  assign rd1_mask = in1 ? rd_q : '0;

  logic signed [16:0] dl, dr;
  logic signed [15:0] l0, l1, r0, r1;
  assign l0 = w0_q[15:0];
  assign r0 = w0_q[31:16];
  assign l1 = rd1_mask[15:0];
  assign r1 = rd1_mask[31:16];
  assign dl = 17'(l1) - 17'(l0);
  assign dr = 17'(r1) - 17'(r0);
  logic signed [16+FRAC_BITS+1:0] pl, pr;
  assign pl = dl * $signed({1'b0, frac});
  assign pr = dr * $signed({1'b0, frac});
  logic signed [16:0] ofs_l, ofs_r;
  assign ofs_l = 17'(pl >>> FRAC_BITS);
  assign ofs_r = 17'(pr >>> FRAC_BITS);

  logic signed [25:0] env_s;
  logic signed [16:0] vgain_s;
  assign env_s = $signed({1'b0, env});
  assign vgain_s = $signed({1'b0, vgain});

  logic signed [58:0] sl, sr;
  assign sl = ml_q * vgain_s;
  assign sr = mr_q * vgain_s;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k_q <= kind;
      a_q <= sample_address;
      w_q <= {sample_right, sample_left};
      vel_in_q <= velocity;
      step_in_q <= pitch_step;
      tail_q <= tail_off;
    end
    if (cmd.op == OP_RD0 || cmd.op == OP_RD1) begin
      rd_q <= mem[(cmd.op == OP_RD0) ? i0[AW-1:0] : i1[AW-1:0]];
    end
    // a 16-bit address always lies inside the memory
    if (dec_q && k_q == KIND_LOAD) begin
      mem[a_q] <= w_q;
    end
    case (cmd.op)
      OP_ENV_MUL: begin
        prod_a <= 50'(coef) * 50'(level);
        prod_b <= 50'(ENV_ONE - 25'(coef)) * 50'(tgt);
      end
      OP_RD1: w0_q <= in0 ? rd_q : '0;
      OP_INTERP: begin
        il_q <= 16'(17'(l0) + ofs_l);
        ir_q <= 16'(17'(r0) + ofs_r);
      end
      OP_SCALE1: begin
        ml_q <= il_q * env_s;
        mr_q <= (source_stereo ? ir_q : il_q) * env_s;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) dec_q <= 1'b0;
    else dec_q <= cmd.start;
  end

  // control state of the voice
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      level <= '0;
      pos <= '0;
      vgain <= '0;
      nstep <= '0;
      env <= '0;
      hold_left <= '0;
      hold_right <= '0;
      hold_env <= '0;
      hold_active <= 1'b0;
      res_active <= 1'b0;
      res_left <= '0;
      res_right <= '0;
      res_env <= '0;
    end else begin
      if (dec_q && k_q == KIND_NOTE_ON) begin
        vgain <= vel_in_q;
        nstep <= step_in_q;
        pos <= '0;
        phase <= PH_ATTACK;
      end
      if (dec_q && k_q == KIND_NOTE_OFF) begin
        if (tail_q) begin
          if (phase != PH_IDLE) phase <= PH_RELEASE;
        end else begin
          phase <= PH_IDLE;
          level <= '0;
          pos <= '0;
        end
      end
      if (dec_q && k_q == KIND_TICK && sts.skip) begin
        hold_left <= '0;
        hold_right <= '0;
        hold_env <= '0;
        hold_active <= phase_live;
      end
      if (cmd.op == OP_ENV_FIN) begin
        unique case (phase)
          PH_ATTACK: begin
            if (lvl_new >= ENV_ONE) begin
              level <= ENV_ONE; env <= ENV_ONE; phase <= PH_DECAY;
            end else begin
              level <= lvl_new; env <= lvl_new;
            end
          end
          PH_DECAY: begin
            level <= lvl_new; env <= lvl_new;
            if ((lvl_new >= sus ? lvl_new - sus : sus - lvl_new) < DECAY_NEAR)
              phase <= PH_SUSTAIN;
          end
          PH_SUSTAIN: env <= sus;
          default: begin
            level <= lvl_new;
            env <= (lvl_new < RELEASE_FLOOR) ? '0 : lvl_new;
            if (lvl_new < RELEASE_FLOOR) phase <= PH_IDLE;
          end
        endcase
      end
      if (cmd.op == OP_SCALE2) begin
        hold_left <= 16'(sl >>> 40);
        hold_right <= 16'(sr >>> 40);
        hold_env <= env;
        pos <= pos_sum;
        if ({1'b0, pos_sum} >= len_pos && phase != PH_IDLE && phase != PH_RELEASE) begin
          phase <= PH_RELEASE;
          hold_active <= 1'b1;
        end else begin
          hold_active <= (phase != PH_IDLE);
        end
      end
      // output register only changes once the previous word is gone
      if (cmd.finish) begin
        res_left <= hold_left;
        res_right <= hold_right;
        res_env <= hold_env;
        res_active <= hold_active;
      end
    end
  end

  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SCALE2 |=> pos >= $past(pos)) else $error("position went back");
  a_env_max: assert property (@(posedge clk) disable iff (rst)
    res_env <= ENV_ONE) else $error("envelope above one");
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ENV_FIN && phase == PH_RELEASE && lvl_new < RELEASE_FLOOR) |=>
    env == '0) else $error("release floor not zeroed");
endmodule
